// File: sv/murmur3_x64_hash_engine_unit_macros.svh
// Assertion macros used by the checker file of the murmur3 x64 hash engine.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef MURMUR3_X64_HASH_ENGINE_UNIT_MACROS_SVH
`define MURMUR3_X64_HASH_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define M3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/m3x64_pkg.sv
// Constants and helpers for the murmur3 x64-128 hash engine.
// No dependencies; imported by murmur3_x64_hash_engine_unit.
package m3x64_pkg;

    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] MM_A1 = 64'h0000000052dce729;
    localparam logic [63:0] MM_A2 = 64'h0000000038495ab5;

    localparam int unsigned BLOCK_BYTES = 16;
    localparam logic [4:0]  VB_FULL     = 5'(BLOCK_BYTES);
    localparam logic [4:0]  VB_HALF     = 5'(BLOCK_BYTES / 2);

    // register index, taken from paddr[2]
    localparam logic REG_SEED = 1'b0;

    // low n bytes set; n of 8 or more gives all ones
    function automatic logic [63:0] byte_mask(input logic [4:0] n);
        logic [63:0] m;
        if (n >= VB_HALF) begin
            m = '1;
        end else begin
            m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
        end
        return m;
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] v);
        return v ^ (v >> 33);
    endfunction

endpackage

// File: sv/murmur3_x64_hash_engine_unit.sv
// Top level of the murmur3 x64-128 hash engine (first 64-bit half of the result).
// Depends on m3x64_pkg; one shared 32x32 multiplier under a one-hot sequencer.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+-----------------------------------
//  in       | i_in_valid / o_in_ready            | i_block_low, i_block_high,
//           |                                    | i_valid_bytes, i_last_block
//  out      | o_out_valid / i_out_ready          | o_hash_value
//  config   | psel, penable, pwrite / pready     | paddr, pwdata, prdata (seed)
//
// Each 64-bit constant product is formed from 32x32 partial products on the shared multiplier.
// A block is taken only in ST_IDLE, so the next item waits until the current one is absorbed.
// A last block also runs the finalization; an empty one skips the block mixing.
// The result sits in an output register; only a second result waits for it.
// Reset is synchronous; it clears control state and the seed.
module murmur3_x64_hash_engine_unit
    import m3x64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_last_block,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_K1A  = 14'b00000000000010,
        ST_K1B  = 14'b00000000000100,
        ST_H1   = 14'b00000000001000,
        ST_K2A  = 14'b00000000010000,
        ST_K2B  = 14'b00000000100000,
        ST_H2   = 14'b00000001000000,
        ST_FIN0 = 14'b00000010000000,
        ST_FIN1 = 14'b00000100000000,
        ST_F1A  = 14'b00001000000000,
        ST_F1B  = 14'b00010000000000,
        ST_F2A  = 14'b00100000000000,
        ST_F2B  = 14'b01000000000000,
        ST_SUM  = 14'b10000000000000
    } t_state;

    localparam logic [1:0] PH_LAST = 2'd3;

    t_state      r_state, n_state;
    logic [1:0]  r_ph, n_ph;
    logic [63:0] r_m, n_m;
    logic [63:0] r_prod, n_prod;
    logic [63:0] r_hi, n_hi;
    logic [63:0] r_h1, n_h1;
    logic [63:0] r_h2, n_h2;
    logic [63:0] r_len, n_len;
    logic        r_inside, n_inside;
    logic        r_full, n_full;
    logic        r_last, n_last;
    logic        r_do2, n_do2;
    logic [31:0] r_seed, n_seed;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash, n_hash;

    logic        w_in_acc;
    logic        w_cfg_wr;
    logic [4:0]  w_vb;
    logic        w_full;
    logic [63:0] w_lo;
    logic [63:0] w_hi;
    logic [63:0] w_h1s;
    logic [63:0] w_h2s;
    logic [63:0] w_lens;
    logic        w_is_mul;
    logic [63:0] w_const;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_p32;
    logic        w_mul_done;
    logic [63:0] w_t1;
    logic [63:0] w_t2;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_SEED) ? r_seed : 32'd0;

    assign w_in_acc = i_in_valid & o_in_ready;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    assign w_vb   = (i_valid_bytes > VB_FULL) ? VB_FULL : i_valid_bytes;
    assign w_full = !i_last_block || (w_vb == VB_FULL);
    assign w_lo   = w_full ? i_block_low  : (i_block_low & byte_mask(w_vb));
    assign w_hi   = w_full ? i_block_high : (i_block_high & byte_mask(w_vb - VB_HALF));
    assign w_h1s  = r_inside ? r_h1  : {32'd0, r_seed};
    assign w_h2s  = r_inside ? r_h2  : {32'd0, r_seed};
    assign w_lens = r_inside ? r_len : 64'd0;

    // shared multiplier: low x low, high x low, low x high, then post-op
    always_comb begin
        w_is_mul = 1'b1;
        w_const  = 64'd0;
        case (r_state) inside
            ST_K1A, ST_K2B: w_const = MM_C1;
            ST_K1B, ST_K2A: w_const = MM_C2;
            ST_F1A, ST_F2A: w_const = MM_F1;
            ST_F1B, ST_F2B: w_const = MM_F2;
            default:        w_is_mul = 1'b0;
        endcase
    end

    assign w_ma       = (r_ph == 2'd1) ? r_m[63:32] : r_m[31:0];
    assign w_mb       = (r_ph == 2'd2) ? w_const[63:32] : w_const[31:0];
    assign w_p32      = w_ma * w_mb;
    assign w_mul_done = w_is_mul && (r_ph == PH_LAST);

    assign w_t1 = r_h1 ^ r_prod;
    assign w_t2 = r_h2 ^ r_prod;

    always_comb begin
        n_state     = r_state;
        n_ph        = r_ph;
        n_m         = r_m;
        n_prod      = r_prod;
        n_hi        = r_hi;
        n_h1        = r_h1;
        n_h2        = r_h2;
        n_len       = r_len;
        n_inside    = r_inside;
        n_full      = r_full;
        n_last      = r_last;
        n_do2       = r_do2;
        n_seed      = r_seed;
        n_out_valid = r_out_valid;
        n_hash      = r_hash;

        if (w_cfg_wr && (paddr[2] == REG_SEED)) begin
            n_seed = pwdata;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_is_mul) begin
            n_ph = r_ph + 2'd1;
            case (r_ph)
                2'd0:    n_prod = w_p32;
                2'd1,
                2'd2:    n_prod = r_prod + {w_p32[31:0], 32'd0};
                default: n_prod = r_prod;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_h1     = w_h1s;
                    n_h2     = w_h2s;
                    n_len    = w_lens + (w_full ? 64'(BLOCK_BYTES) : {59'd0, w_vb});
                    n_inside = !i_last_block;
                    n_full   = w_full;
                    n_last   = i_last_block;
                    n_do2    = (w_vb > VB_HALF);
                    n_hi     = w_hi;
                    n_m      = w_lo;
                    n_ph     = 2'd0;
                    n_state  = (w_full || (w_vb != 5'd0)) ? ST_K1A : ST_FIN0;
                end
            end
            ST_K1A: begin
                if (w_mul_done) begin
                    n_m     = {r_prod[32:0], r_prod[63:33]};
                    n_state = ST_K1B;
                end
            end
            ST_K1B: begin
                if (w_mul_done) begin
                    if (r_full) begin
                        n_h1    = {w_t1[36:0], w_t1[63:37]} + r_h2;
                        n_state = ST_H1;
                    end else if (r_do2) begin
                        n_h1    = w_t1;
                        n_m     = r_hi;
                        n_state = ST_K2A;
                    end else begin
                        n_h1    = w_t1;
                        n_state = ST_FIN0;
                    end
                end
            end
            ST_H1: begin
                n_h1    = (r_h1 << 2) + r_h1 + MM_A1;
                n_m     = r_hi;
                n_state = ST_K2A;
            end
            ST_K2A: begin
                if (w_mul_done) begin
                    n_m     = {r_prod[30:0], r_prod[63:31]};
                    n_state = ST_K2B;
                end
            end
            ST_K2B: begin
                if (w_mul_done) begin
                    if (r_full) begin
                        n_h2    = {w_t2[32:0], w_t2[63:33]} + r_h1;
                        n_state = ST_H2;
                    end else begin
                        n_h2    = w_t2;
                        n_state = ST_FIN0;
                    end
                end
            end
            ST_H2: begin
                n_h2    = (r_h2 << 2) + r_h2 + MM_A2;
                n_state = r_last ? ST_FIN0 : ST_IDLE;
            end
            ST_FIN0: begin
                n_h1    = (r_h1 ^ r_len) + (r_h2 ^ r_len);
                n_h2    = r_h2 ^ r_len;
                n_state = ST_FIN1;
            end
            ST_FIN1: begin
                n_h2    = r_h2 + r_h1;
                n_m     = xs33(r_h1);
                n_ph    = 2'd0;
                n_state = ST_F1A;
            end
            ST_F1A: begin
                if (w_mul_done) begin
                    n_m     = xs33(r_prod);
                    n_state = ST_F1B;
                end
            end
            ST_F1B: begin
                if (w_mul_done) begin
                    n_h1    = xs33(r_prod);
                    n_m     = xs33(r_h2);
                    n_state = ST_F2A;
                end
            end
            ST_F2A: begin
                if (w_mul_done) begin
                    n_m     = xs33(r_prod);
                    n_state = ST_F2B;
                end
            end
            ST_F2B: begin
                if (w_mul_done) begin
                    n_h2    = xs33(r_prod);
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_hash      = r_h1 + r_h2;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= 2'd0;
            r_h1        <= 64'd0;
            r_h2        <= 64'd0;
            r_len       <= 64'd0;
            r_inside    <= 1'b0;
            r_full      <= 1'b0;
            r_last      <= 1'b0;
            r_do2       <= 1'b0;
            r_seed      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ph        <= n_ph;
            r_h1        <= n_h1;
            r_h2        <= n_h2;
            r_len       <= n_len;
            r_inside    <= n_inside;
            r_full      <= n_full;
            r_last      <= n_last;
            r_do2       <= n_do2;
            r_seed      <= n_seed;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_prod <= n_prod;
        r_hi   <= n_hi;
        r_hash <= n_hash;
    end

endmodule

// File: sv/m3x64_checker.sv
// Port-level checker for murmur3_x64_hash_engine_unit, bound to the top level.
// Depends on murmur3_x64_hash_engine_unit_macros.svh.
`include "murmur3_x64_hash_engine_unit_macros.svh"

module m3x64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_hash_value,
    input logic        pready
);

    `M3_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hash_value), "result item dropped or changed while stalled")
    `M3_ASSERT_NXT(a_busy_after_item, i_in_valid && o_in_ready, !o_in_ready, "input ready right after taking an item")
    `M3_ASSERT_NXT(a_no_instant_result, i_in_valid && o_in_ready, !$rose(o_out_valid), "result item appeared one cycle after an input item")
    `M3_ASSERT_IMP(a_reset_clears_out, $past(!i_rst_n), !o_out_valid && pready, "output valid or pready wrong after reset")

endmodule

bind murmur3_x64_hash_engine_unit m3x64_checker u_m3x64_checker (.*);

// File: verif/murmur3_x64_hash_engine_unit_test.sv
// Testbench for murmur3_x64_hash_engine_unit: directed block table, then random keys.
// Each hash is checked against an in-bench murmur3 x64-128 predictor or a known table value; needs m3x64_pkg.
`timescale 1ns / 1ps

module murmur3_x64_hash_engine_unit_test
    import m3x64_pkg::*;
();

    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int RESET_CYCLES   = 12;
    localparam int PHASE_BLOCKS   = 100;
    localparam int NUM_PHASES     = 6;
    localparam logic [2:0]  SEED_ADDR = {REG_SEED, 2'b00};
    localparam logic [63:0] ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  vb;
        logic        last;
        logic        set_seed;
        logic [31:0] seed_val;
        logic        known;
        logic [63:0] known_hash;
    } t_block_row;

    localparam int N_DIR = 21;
    localparam t_block_row DIR_ROWS [N_DIR] = '{
        // empty key, zero seed: all-zero hash
        '{64'd0, 64'd0, 5'd0, 1'b1, 1'b0, 32'd0, 1'b1, 64'd0},
        '{ONES, ONES, 5'd16, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{ONES, ONES, 5'd1, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{ONES, ONES, 5'd8, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{ONES, ONES, 5'd9, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        // byte counts above a block saturate
        '{ONES, ONES, 5'd31, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'd0, 64'd0, 5'd17, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        // short body block still counts as full
        '{ONES, ONES, 5'd3, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd5, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'd0, 64'd0, 5'd16, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'd0},
        '{ONES, ONES, 5'd0, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0},
        // seed change mid-key applies from the next key
        '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd0, 1'b1, 1'b1, 32'h1234_5678,
          1'b0, 64'd0},
        '{64'd0, 64'd0, 5'd0, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'd0, 64'd0, 5'd0, 1'b1, 1'b1, 32'd0, 1'b1, 64'd0},
        '{ONES, 64'd0, 5'd12, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'd0, ONES, 5'd16, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'h8000000000000000, 64'h8000000000000001, 5'd10, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0},
        '{64'd1, 64'd0, 5'd2, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'd0},
        '{64'd0, 64'd0, 5'd0, 1'b0, 1'b0, 32'd0, 1'b0, 64'd0},
        '{ONES, ONES, 5'd30, 1'b1, 1'b0, 32'd0, 1'b0, 64'd0}
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_block_low   = '0;
    logic [63:0] i_block_high  = '0;
    logic [4:0]  i_valid_bytes = '0;
    logic        i_last_block  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [63:0] o_hash_value;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    murmur3_x64_hash_engine_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_block_low   (i_block_low),
        .i_block_high  (i_block_high),
        .i_valid_bytes (i_valid_bytes),
        .i_last_block  (i_last_block),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_hash_value  (o_hash_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [31:0] seed_shadow = '0;
    logic [63:0] acc_one     = '0;
    logic [63:0] acc_two     = '0;
    logic [63:0] bytes_seen  = '0;
    bit          key_open    = 1'b0;

    logic [63:0] pending_hashes [$];
    int          error_count   = 0;
    int          blocks_sent   = 0;
    int          keys_sent     = 0;
    int          hashes_seen   = 0;
    int          seed_writes   = 0;
    int          cycle_count   = 0;
    int          sink_hold     = 0;
    bit          steady_phase  = 1'b0;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic logic [63:0] fmix64(input logic [63:0] v);
        logic [63:0] x;
        x = v ^ (v >> 33);
        x = x * MM_F1;
        x = x ^ (x >> 33);
        x = x * MM_F2;
        return x ^ (x >> 33);
    endfunction

    function automatic logic [63:0] scramble_lo(input logic [63:0] k);
        return rotl64(k * MM_C1, 31) * MM_C2;
    endfunction

    function automatic logic [63:0] scramble_hi(input logic [63:0] k);
        return rotl64(k * MM_C2, 33) * MM_C1;
    endfunction

    function automatic logic [63:0] low_bytes_mask(input logic [4:0] n);
        if (n >= VB_HALF) begin
            return ONES;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // absorbs one block; returns 1 with the digest when the key ends
    function automatic bit hash_absorb(input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [4:0] vb_in, input logic last,
                                       output logic [63:0] digest);
        logic [4:0]  vb;
        logic [63:0] f1;
        logic [63:0] f2;
        vb = (vb_in > VB_FULL) ? VB_FULL : vb_in;
        digest = '0;
        if (!key_open) begin
            acc_one = {32'd0, seed_shadow};
            acc_two = {32'd0, seed_shadow};
            bytes_seen = '0;
            key_open = 1'b1;
        end
        if (!last || vb == VB_FULL) begin
            acc_one = rotl64(acc_one ^ scramble_lo(lo), 27) + acc_two;
            acc_one = acc_one * 64'd5 + MM_A1;
            acc_two = rotl64(acc_two ^ scramble_hi(hi), 31) + acc_one;
            acc_two = acc_two * 64'd5 + MM_A2;
        end else begin
            if (vb > VB_HALF) begin
                acc_two = acc_two ^ scramble_hi(hi & low_bytes_mask(vb - VB_HALF));
            end
            if (vb != 5'd0) begin
                acc_one = acc_one ^ scramble_lo(lo & low_bytes_mask(vb));
            end
        end
        if (!last) begin
            bytes_seen = bytes_seen + 64'(BLOCK_BYTES);
            return 1'b0;
        end
        bytes_seen = bytes_seen + 64'(vb);
        f1 = acc_one ^ bytes_seen;
        f2 = acc_two ^ bytes_seen;
        f1 = f1 + f2;
        f2 = f2 + f1;
        f1 = fmix64(f1);
        f2 = fmix64(f2);
        digest = f1 + f2;
        key_open = 1'b0;
        return 1'b1;
    endfunction

    function automatic int idle_span();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return ONES;
        end
        if (r == 1) begin
            return '0;
        end
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [4:0] vb, input logic last,
                              input bit use_known, input logic [63:0] known_hash);
        int          gap;
        logic [63:0] digest;
        gap = (steady_phase || $urandom_range(0, 1) == 0) ? 0 : idle_span();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_block_low   <= lo;
        i_block_high  <= hi;
        i_valid_bytes <= vb;
        i_last_block  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        blocks_sent++;
        if (hash_absorb(lo, hi, vb, last, digest)) begin
            pending_hashes.push_back(use_known ? known_hash : digest);
            keys_sent++;
        end
    endtask

    task automatic send_random_key();
        int         r;
        int         body;
        logic [4:0] vb;
        r = $urandom_range(0, 99);
        body = (r < 45) ? 0 : (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 9);
        for (int b = 0; b < body; b++) begin
            // odd byte counts on body blocks are ignored
            vb = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : VB_FULL;
            send_block(rand_word(), rand_word(), vb, 1'b0, 1'b0, '0);
        end
        r = $urandom_range(0, 9);
        vb = (r == 0) ? VB_FULL : (r == 1) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
        send_block(rand_word(), rand_word(), vb, 1'b1, 1'b0, '0);
    endtask

    task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SEED_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_seed(input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, value, rd);
        seed_shadow = value;
        seed_writes++;
        apb_xfer(1'b0, '0, rd);
        if (rd !== value) begin
            $display("%0t: seed readback mismatch, expected %h, got %h", $time, value, rd);
            error_count++;
        end
    endtask

    // engine may still be absorbing a body block after the last hash
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            hashes_seen++;
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash, expected none, got %h", $time, o_hash_value);
                error_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (o_hash_value !== want) begin
                    $display("%0t: hash mismatch, expected %h, got %h",
                             $time, want, o_hash_value);
                    error_count++;
                end
            end
        end
        if (steady_phase) begin
            sink_hold = 0;
            i_out_ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 15) begin
            sink_hold = idle_span() - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d hashes outstanding", $time, pending_hashes.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [31:0] phase_seed;
        int          phase_start;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].set_seed) begin
                drain_results();
                write_seed(DIR_ROWS[i].seed_val);
            end
            send_block(DIR_ROWS[i].lo, DIR_ROWS[i].hi, DIR_ROWS[i].vb, DIR_ROWS[i].last,
                       DIR_ROWS[i].known, DIR_ROWS[i].known_hash);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            case (p)
                0: phase_seed = 32'hFFFF_FFFF;
                2: phase_seed = 32'h0000_0000;
                4: phase_seed = 32'h8000_0001;
                default: phase_seed = $urandom();
            endcase
            write_seed(phase_seed);
            steady_phase = (p == 2);
            phase_start = blocks_sent;
            while (blocks_sent - phase_start < PHASE_BLOCKS) begin
                send_random_key();
            end
        end

        drain_results();
        steady_phase = 1'b0;
        $display("Sent %0d blocks forming %0d keys under %0d seed settings; %0d hashes checked.",
                 blocks_sent, keys_sent, seed_writes + 1, hashes_seen);
        $display("Mismatches and protocol errors: %0d", error_count);
        if (error_count == 0 && pending_hashes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
